/* rtl/bpmp_pkg.sv */
// Shared types, constants and helpers for the BLE power measurement parser.
`default_nettype none
package bpmp_pkg;

    // Configuration register indexes
    localparam logic CFG_IDX_FTMS_MODE = 1'b0;
    localparam logic CFG_IDX_MAX_POWER = 1'b1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;
    localparam int POWER_W    = 15;

    localparam logic [POWER_W-1:0] MAX_POWER_RESET = 15'd3000;

    // Indoor bike data flag bits
    localparam logic [15:0] FLAG_MORE_DATA   = 16'h0001;
    localparam logic [15:0] FLAG_AVG_SPEED   = 16'h0002;
    localparam logic [15:0] FLAG_CADENCE     = 16'h0004;
    localparam logic [15:0] FLAG_AVG_CADENCE = 16'h0008;
    localparam logic [15:0] FLAG_DISTANCE    = 16'h0010;
    localparam logic [15:0] FLAG_RESISTANCE  = 16'h0020;
    localparam logic [15:0] FLAG_POWER       = 16'h0040;

    // Power offset in cycling power measurement packets
    localparam logic [3:0] CPM_POWER_OFFSET = 4'd2;
    localparam logic [7:0] POS_MAX          = 8'd255;
    localparam logic [7:0] POS_MIN_LAST     = 8'd3;

    // One input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    // Configuration seen by the parser
    typedef struct packed {
        logic               ftms_mode;
        logic [POWER_W-1:0] max_power;
    } cfg_t;

    // Byte index of the power field in an indoor bike data packet
    function automatic logic [3:0] offset_from_flags(input logic [15:0] f);
        logic [4:0] off;
        off = 5'd2;
        if ((f & FLAG_MORE_DATA) == 16'h0)   off = off + 5'd2;
        if ((f & FLAG_AVG_SPEED) != 16'h0)   off = off + 5'd2;
        if ((f & FLAG_CADENCE) != 16'h0)     off = off + 5'd2;
        if ((f & FLAG_AVG_CADENCE) != 16'h0) off = off + 5'd2;
        if ((f & FLAG_DISTANCE) != 16'h0)    off = off + 5'd3;
        if ((f & FLAG_RESISTANCE) != 16'h0)  off = off + 5'd2;
        return off[3:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/bpmp_in_stage.sv */
// Input register stage for the BLE power measurement parser.
`default_nettype none
module bpmp_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire bpmp_pkg::in_word_t s_word,
    input  wire logic              advance,
    output logic                   in_valid,
    output bpmp_pkg::in_word_t     in_word
);
    import bpmp_pkg::*;

    logic     in_valid_reg;
    logic     in_valid_next;
    in_word_t in_word_reg;

    // Take a word when empty or when the held word moves on this cycle
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_word;
        end
    end

    assign in_valid = in_valid_reg;
    assign in_word  = in_word_reg;

endmodule
`default_nettype wire

/* rtl/bpmp_parse.sv */
// Packet state tracking and result register for the BLE power measurement parser.
`default_nettype none
module bpmp_parse (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bpmp_pkg::cfg_t                cfg,
    input  wire logic                          in_valid,
    input  wire bpmp_pkg::in_word_t            in_word,
    output logic                               advance,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [bpmp_pkg::POWER_W-1:0]       m_power_watts
);
    import bpmp_pkg::*;

    logic [7:0]         byte_position_reg,  byte_position_next;
    logic [15:0]        flag_word_reg,      flag_word_next;
    logic [3:0]         power_offset_reg,   power_offset_next;
    logic [7:0]         power_low_byte_reg, power_low_byte_next;
    logic [15:0]        power_word_reg,     power_word_next;
    logic               power_captured_reg, power_captured_next;
    logic               out_valid_reg,      out_valid_next;
    logic [POWER_W-1:0] out_power_reg,      out_power_next;

    logic               step;
    logic               ok;
    logic [POWER_W-1:0] clamped;
    logic [7:0]         off_lo;
    logic [7:0]         off_hi;

    // Move on whenever the result register is free or being drained
    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid && advance;

    assign off_lo = {4'h0, power_offset_reg};
    assign off_hi = off_lo + 8'd1;

    // Per-byte state update and result check
    always_comb begin
        byte_position_next  = byte_position_reg;
        flag_word_next      = flag_word_reg;
        power_offset_next   = power_offset_reg;
        power_low_byte_next = power_low_byte_reg;
        power_word_next     = power_word_reg;
        power_captured_next = power_captured_reg;
        out_valid_next      = out_valid_reg;
        out_power_next      = out_power_reg;
        ok                  = 1'b0;
        clamped             = '0;

        if (advance) begin
            out_valid_next = 1'b0;
        end

        if (step) begin
            if (byte_position_reg == 8'd0) begin
                flag_word_next = {8'h00, in_word.data_byte};
            end else if (byte_position_reg == 8'd1) begin
                flag_word_next    = {in_word.data_byte, flag_word_reg[7:0]};
                power_offset_next = cfg.ftms_mode ? offset_from_flags(flag_word_next)
                                                  : CPM_POWER_OFFSET;
            end else if (!power_captured_reg) begin
                if (byte_position_reg == off_lo) begin
                    power_low_byte_next = in_word.data_byte;
                end else if (byte_position_reg == off_hi) begin
                    power_word_next     = {in_word.data_byte, power_low_byte_reg};
                    power_captured_next = 1'b1;
                end
            end

            if (byte_position_reg != POS_MAX) begin
                byte_position_next = byte_position_reg + 8'd1;
            end

            if (in_word.last_byte) begin
                ok = (byte_position_reg >= POS_MIN_LAST) && power_captured_next;
                if (cfg.ftms_mode && ((flag_word_next & FLAG_POWER) == 16'h0)) begin
                    ok = 1'b0;
                end
                // Negative power reads as zero
                clamped = power_word_next[15] ? '0 : power_word_next[POWER_W-1:0];
                if (ok && (clamped <= cfg.max_power)) begin
                    out_valid_next = 1'b1;
                    out_power_next = clamped;
                end
                // End of packet: start fresh
                byte_position_next  = '0;
                flag_word_next      = '0;
                power_offset_next   = '0;
                power_low_byte_next = '0;
                power_word_next     = '0;
                power_captured_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg  <= '0;
            flag_word_reg      <= '0;
            power_offset_reg   <= '0;
            power_low_byte_reg <= '0;
            power_word_reg     <= '0;
            power_captured_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
        end else begin
            byte_position_reg  <= byte_position_next;
            flag_word_reg      <= flag_word_next;
            power_offset_reg   <= power_offset_next;
            power_low_byte_reg <= power_low_byte_next;
            power_word_reg     <= power_word_next;
            power_captured_reg <= power_captured_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge aclk) begin
        out_power_reg <= out_power_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_power_watts = out_power_reg;

endmodule
`default_nettype wire

/* rtl/ble_power_measurement_parser_unit.sv */
// Top level of the BLE power measurement parser: config registers and stage wiring.
//
// Usage:
//   The s_ channel carries one packet byte per word (s_data_byte) with
//   s_last_byte marking the packet's final byte. The m_ channel returns at
//   most one word per packet, m_power_watts, at the packet's last byte.
//   cfg_wr_en/cfg_addr/cfg_wdata write ftms_mode (index 0) or max_power
//   (index 1); write only while the block is idle.
//   Throughput: one byte per cycle while no result waits or m_ready is high,
//   set by the single parse step between the input and result registers.
//   Result path: the last byte lands in the input register, then the parse
//   step loads the result register, which drives m_valid; while a result
//   waits and m_ready is low, the byte is held in the input register.
//   Reset (aresetn low, synchronous): packet state cleared, no word held,
//   ftms_mode = 0, max_power = 3000.
//   Stall: while m_ready is low and a result waits, an empty input register
//   still takes one more byte; then s_ready drops until the result is taken.
`default_nettype none
module ble_power_measurement_parser_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [7:0]                          s_data_byte,
    input  wire logic                                s_last_byte,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [bpmp_pkg::POWER_W-1:0]             m_power_watts,
    input  wire logic                                cfg_wr_en,
    input  wire logic [bpmp_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [bpmp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import bpmp_pkg::*;

    logic               ftms_mode_reg;
    logic [POWER_W-1:0] max_power_reg;
    cfg_t               cfg;
    in_word_t           s_word;
    in_word_t           in_word;
    logic               in_valid;
    logic               advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ftms_mode_reg <= 1'b0;
            max_power_reg <= MAX_POWER_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_IDX_FTMS_MODE: ftms_mode_reg <= cfg_wdata[0];
                CFG_IDX_MAX_POWER: max_power_reg <= cfg_wdata[POWER_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.ftms_mode = ftms_mode_reg;
    assign cfg.max_power = max_power_reg;

    assign s_word.data_byte = s_data_byte;
    assign s_word.last_byte = s_last_byte;

    bpmp_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_word   (s_word),
        .advance  (advance),
        .in_valid (in_valid),
        .in_word  (in_word)
    );

    bpmp_parse u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_word       (in_word),
        .advance       (advance),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_power_watts (m_power_watts)
    );

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the BLE power measurement parser unit.
`timescale 1ns / 100ps
module testbench;
    import bpmp_pkg::*;

    // Directed rows are either one input word or one register write
    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [7:0]         data;
        logic               last;
        logic               pinned;
        logic               want_hit;
        logic [POWER_W-1:0] want_watts;
        logic               reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_data_byte = 8'h00;
    logic                  s_last_byte = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [POWER_W-1:0]    m_power_watts;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Typed-in expectation travelling with the word being offered
    logic                  pin_on = 1'b0;
    logic                  pin_hit = 1'b0;
    logic [POWER_W-1:0]    pin_watts = '0;

    // Predictor copy of configuration and packet state
    logic                  pred_ftms = 1'b0;
    logic [POWER_W-1:0]    pred_max = MAX_POWER_RESET;
    logic [7:0]            pkt_pos = '0;
    logic [15:0]           pkt_flags = '0;
    logic [3:0]            pkt_pwr_ofs = '0;
    logic [7:0]            pkt_pwr_lo = '0;
    logic [15:0]           pkt_pwr_word = '0;
    logic                  pkt_pwr_seen = 1'b0;

    logic [POWER_W-1:0]    watts_due[$];
    int                    n_errors = 0;
    int                    results_seen = 0;
    int                    words_sent = 0;
    int                    burst_left = 0;

    // Stimulus-side view of the configuration
    logic                  cur_ftms = 1'b0;
    logic [POWER_W-1:0]    cur_max = MAX_POWER_RESET;

    dir_row_t              dir_rows[$];

    ble_power_measurement_parser_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_power_watts (m_power_watts),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endtask

    // Index of the power low byte in an indoor bike data packet
    function automatic logic [3:0] power_index(input logic [15:0] f);
        logic [4:0] n;
        n = 5'd2;
        n += ((f & FLAG_MORE_DATA) == 16'h0)   ? 5'd2 : 5'd0;
        n += ((f & FLAG_AVG_SPEED) != 16'h0)   ? 5'd2 : 5'd0;
        n += ((f & FLAG_CADENCE) != 16'h0)     ? 5'd2 : 5'd0;
        n += ((f & FLAG_AVG_CADENCE) != 16'h0) ? 5'd2 : 5'd0;
        n += ((f & FLAG_DISTANCE) != 16'h0)    ? 5'd3 : 5'd0;
        n += ((f & FLAG_RESISTANCE) != 16'h0)  ? 5'd2 : 5'd0;
        return n[3:0];
    endfunction

    // Advance the packet state by one byte; hit when a power word comes out
    task automatic predict_power(input logic [7:0] b, input logic l,
                                 output logic hit, output logic [POWER_W-1:0] watts);
        logic [7:0]  pos;
        logic [15:0] clamped;
        pos = pkt_pos;
        hit = 1'b0;
        watts = '0;
        if (pos == 8'd0) begin
            pkt_flags = {8'h00, b};
        end else if (pos == 8'd1) begin
            pkt_flags[15:8] = b;
            pkt_pwr_ofs = pred_ftms ? power_index(pkt_flags) : CPM_POWER_OFFSET;
        end else if (!pkt_pwr_seen) begin
            if (pos == {4'h0, pkt_pwr_ofs}) begin
                pkt_pwr_lo = b;
            end else if (pos == {4'h0, pkt_pwr_ofs} + 8'd1) begin
                pkt_pwr_word = {b, pkt_pwr_lo};
                pkt_pwr_seen = 1'b1;
            end
        end
        if (pkt_pos != POS_MAX) pkt_pos = pkt_pos + 8'd1;
        if (l) begin
            // flag test uses the mode in force at the last byte
            if (pos >= POS_MIN_LAST && pkt_pwr_seen &&
                !(pred_ftms && (pkt_flags & FLAG_POWER) == 16'h0)) begin
                clamped = pkt_pwr_word[15] ? 16'h0000 : pkt_pwr_word;
                if (clamped <= {1'b0, pred_max}) begin
                    hit = 1'b1;
                    watts = clamped[POWER_W-1:0];
                end
            end
            pkt_pos = '0;
            pkt_flags = '0;
            pkt_pwr_ofs = '0;
            pkt_pwr_lo = '0;
            pkt_pwr_word = '0;
            pkt_pwr_seen = 1'b0;
        end
    endtask

    // Monitor: register writes, accepted words and returned results
    always @(posedge aclk) begin : monitor
        logic               hit;
        logic [POWER_W-1:0] w;
        logic [POWER_W-1:0] want;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_IDX_FTMS_MODE: pred_ftms = cfg_wdata[0];
                    CFG_IDX_MAX_POWER: pred_max = cfg_wdata[POWER_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_power(s_data_byte, s_last_byte, hit, w);
                if (pin_on) begin
                    hit = pin_hit;
                    w = pin_watts;
                end
                if (hit) watts_due.insert(watts_due.size(), w);
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (watts_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected word power_watts=%0d",
                                              m_power_watts));
                end else begin
                    want = watts_due.pop_front();
                    if (m_power_watts !== want)
                        report_mismatch($sformatf("power_watts got %0d want %0d",
                                                  m_power_watts, want));
                end
            end
        end
    end

    // Offer one word in bursts with random gaps; returns at a falling edge
    task automatic send_word(input logic [7:0] d, input logic l, input logic pin,
                             input logic ph, input logic [POWER_W-1:0] pw);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data_byte <= d;
        s_last_byte <= l;
        pin_on <= pin;
        pin_hit <= ph;
        pin_watts <= pw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    // Register write once nothing is in flight
    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
        s_valid <= 1'b0;
        while (watts_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_IDX_FTMS_MODE) cur_ftms = val[0];
        else cur_max = val[POWER_W-1:0];
    endtask

    // Random packet: mostly well formed, some truncated, noise or very long
    task automatic send_packet(input bit force_long);
        logic [7:0]  pkt[$];
        logic [15:0] flags;
        logic [15:0] pw;
        int          ofs;
        int          len;
        int          pick;
        pick = force_long ? 99 : $urandom_range(0, 99);
        if (pick < 10) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
        end else begin
            flags = 16'($urandom_range(0, 16'hFFFF));
            if (cur_ftms && $urandom_range(0, 4) != 0) flags = flags | FLAG_POWER;
            ofs = cur_ftms ? int'(power_index(flags)) : int'(CPM_POWER_OFFSET);
            case ($urandom_range(0, 3))
                0: pw = 16'($urandom_range(0, 16'hFFFF));
                1: pw = 16'($urandom_range(0, cur_max));
                2: pw = {1'b0, cur_max};
                default: pw = {1'b0, cur_max} + 16'd1;
            endcase
            len = ofs + 2 + $urandom_range(0, 3);
            if (pick < 18) len = $urandom_range(1, ofs + 1);
            else if (pick >= 97) len = $urandom_range(256, 300);
            for (int k = 0; k < len; k++) pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
            if (len > 0) pkt[0] = flags[7:0];
            if (len > 1) pkt[1] = flags[15:8];
            if (ofs < len) pkt[ofs] = pw[7:0];
            if (ofs + 1 < len) pkt[ofs + 1] = pw[15:8];
        end
        foreach (pkt[k]) send_word(pkt[k], k == len - 1, 1'b0, 1'b0, '0);
    endtask

    function automatic dir_row_t word_row(input logic [7:0] d, input logic l);
        dir_row_t r;
        r = '{ROW_WORD, d, l, 1'b0, 1'b0, '0, 1'b0, '0};
        return r;
    endfunction

    function automatic dir_row_t last_row(input logic [7:0] d, input logic ph,
                                          input logic [POWER_W-1:0] pw);
        dir_row_t r;
        r = '{ROW_WORD, d, 1'b1, 1'b1, ph, pw, 1'b0, '0};
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic idx, input logic [CFG_DATA_W-1:0] v);
        dir_row_t r;
        r = '{ROW_CFG, 8'h00, 1'b0, 1'b0, 1'b0, '0, idx, v};
        return r;
    endfunction

    // Receiver: changing stall pattern plus one long hold-off
    initial begin : receiver
        int  cyc;
        int  pat;
        bit  held;
        logic rdy;
        cyc = 0;
        pat = 0;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && results_seen >= 10) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
            end
            cyc++;
            if (cyc % 64 == 0) pat = $urandom_range(0, 3);
            case (pat)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 3) != 0);
                2: rdy = ($urandom_range(0, 3) == 0);
                default: rdy = (cyc % 8 == 0);
            endcase
            m_ready <= rdy;
        end
    end

    // Main stimulus
    initial begin : stimulus
        logic                  ph_mode[7];
        logic [CFG_DATA_W-1:0] ph_max[7];
        int                    phase_end;
        dir_row_t              r;

        // cycling power: plain word, short packet, negative, above limit
        dir_rows = '{word_row(8'h00, 1'b0), word_row(8'h00, 1'b0),
                     word_row(8'hC8, 1'b0), last_row(8'h00, 1'b1, 15'd200),
                     word_row(8'h11, 1'b0), word_row(8'h22, 1'b0),
                     last_row(8'h33, 1'b0, '0),
                     word_row(8'h00, 1'b0), word_row(8'h00, 1'b0),
                     word_row(8'hFF, 1'b0), last_row(8'hFF, 1'b1, '0),
                     word_row(8'h00, 1'b0), word_row(8'h00, 1'b0),
                     word_row(8'hFF, 1'b0), last_row(8'h7F, 1'b0, '0),
                     // mode switched after the offset was latched: flag test fails
                     word_row(8'h00, 1'b0), word_row(8'h00, 1'b0),
                     cfg_row(CFG_IDX_FTMS_MODE, 15'd1),
                     word_row(8'h64, 1'b0), last_row(8'h00, 1'b0, '0),
                     // indoor bike: power field past the end of the packet
                     word_row(8'h40, 1'b0), word_row(8'h00, 1'b0),
                     word_row(8'h11, 1'b0), last_row(8'h22, 1'b0, '0),
                     // indoor bike with more-data flag: power at byte 2
                     word_row(8'h41, 1'b0), word_row(8'h00, 1'b0),
                     word_row(8'h2C, 1'b0), word_row(8'h01, 1'b1)};

        ph_mode = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        ph_max = '{15'd32767, 15'd0, 15'd32767, 15'd0, 15'd3000,
                   15'($urandom_range(0, 32767)), 15'($urandom_range(0, 4000))};

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.kind == ROW_CFG) write_reg(r.reg_idx, r.reg_val);
            else send_word(r.data, r.last, r.pinned, r.want_hit, r.want_watts);
        end

        // random phases, each with its own register setting
        for (int p = 0; p < 7; p++) begin
            write_reg(CFG_IDX_FTMS_MODE, {14'd0, ph_mode[p]});
            write_reg(CFG_IDX_MAX_POWER, ph_max[p]);
            phase_end = words_sent + 170;
            send_packet(p == 0);
            while (words_sent < phase_end) send_packet(1'b0);
        end

        s_valid <= 1'b0;
        while (watts_due.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Run limit
    initial begin : watchdog
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
